>>> hw/rtl/mqtt_fixed_header_deframer_macros.svh
// Assertion macros shared by the deframer's checker.
`ifndef MQTT_FIXED_HEADER_DEFRAMER_MACROS_SVH
`define MQTT_FIXED_HEADER_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MFH_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, disabled while reset is low.
`define MFH_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

>>> hw/rtl/mfh_pkg.sv
// Types, constants and codes of the MQTT fixed-header deframer.
`default_nettype none
package mfh_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 28;
    localparam int NIB_W     = 4;
    localparam int CNT_W     = 2;
    localparam int M_TDATA_W = 72;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = {LEN_W{1'b1}};

    // packet types with a fixed remaining length
    localparam logic [NIB_W-1:0] KIND_CONNACK  = 4'd2;
    localparam logic [NIB_W-1:0] KIND_PUBACK   = 4'd4;
    localparam logic [NIB_W-1:0] KIND_PUBREL   = 4'd6;
    localparam logic [NIB_W-1:0] KIND_PUBCOMP  = 4'd7;
    localparam logic [NIB_W-1:0] KIND_PINGRESP = 4'd13;

    localparam logic [6:0] ACK_LENGTH  = 7'd2;
    localparam logic [6:0] PING_LENGTH = 7'd0;
    localparam logic [CNT_W-1:0] LAST_LEN_BYTE = 2'd3;

    typedef enum logic [2:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_ERR_MISMATCH,
        PH_ERR_OVERFLOW
    } phase_t;

    typedef enum logic [1:0] {
        ROLE_TYPE,
        ROLE_LEN,
        ROLE_BODY,
        ROLE_DROP
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_MISMATCH,
        ERR_OVERFLOW
    } err_t;

    typedef struct packed {
        role_t             role;
        logic [NIB_W-1:0]  kind;
        logic [NIB_W-1:0]  flags;
        logic [LEN_W-1:0]  rlen;
        logic [LEN_W-1:0]  offset;
        logic              eop;
        err_t              err;
    } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/mfh_in_stage.sv
// Input register: holds one received byte until the parser takes it.
`default_nettype none
module mfh_in_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [mfh_pkg::BYTE_W-1:0] s_tdata,
    input  wire logic                       advance,
    output logic                            byte_valid,
    output logic [mfh_pkg::BYTE_W-1:0]      byte_data
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [mfh_pkg::BYTE_W-1:0] byte_reg;
    logic                       take;

    assign s_tready = !valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mfh_parser.sv
// Framing state and per-byte decode of the MQTT fixed header.
`default_nettype none
module mfh_parser (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [mfh_pkg::LEN_W-1:0]  cfg_wr_data,
    input  wire logic                       advance,
    input  wire logic [mfh_pkg::BYTE_W-1:0] byte_data,
    output mfh_pkg::result_t                result
);

    mfh_pkg::phase_t              phase_reg, phase_next;
    logic [mfh_pkg::NIB_W-1:0]    kind_reg, kind_next;
    logic [mfh_pkg::NIB_W-1:0]    flags_reg, flags_next;
    logic [mfh_pkg::LEN_W-1:0]    accum_reg, accum_next;
    logic [mfh_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [mfh_pkg::LEN_W-1:0]    body_reg, body_next;
    logic [mfh_pkg::LEN_W-1:0]    max_len_reg;

    logic                         more;
    logic [6:0]                   val;
    logic [mfh_pkg::LEN_W-1:0]    shifted;
    logic [mfh_pkg::LEN_W-1:0]    accum_sum;
    logic                         mismatch;
    logic                         overflow;
    logic [mfh_pkg::LEN_W:0]      off_plus;
    logic                         body_last;

    assign more = byte_data[7];
    assign val  = byte_data[6:0];

    // place the 7-bit group by its position in the length field
    always_comb begin
        case (count_reg)
            2'd0:    shifted = {21'd0, val};
            2'd1:    shifted = {14'd0, val, 7'd0};
            2'd2:    shifted = {7'd0, val, 14'd0};
            default: shifted = {val, 21'd0};
        endcase
    end

    assign accum_sum = accum_reg + shifted;

    always_comb begin
        mismatch = 1'b0;
        if (count_reg == '0) begin
            case (kind_reg)
                mfh_pkg::KIND_CONNACK, mfh_pkg::KIND_PUBACK,
                mfh_pkg::KIND_PUBREL, mfh_pkg::KIND_PUBCOMP:
                    mismatch = more || (val != mfh_pkg::ACK_LENGTH);
                mfh_pkg::KIND_PINGRESP:
                    mismatch = more || (val != mfh_pkg::PING_LENGTH);
                default:
                    mismatch = 1'b0;
            endcase
        end
    end

    assign overflow = more &&
        ((accum_sum > max_len_reg) || (count_reg == mfh_pkg::LAST_LEN_BYTE));

    assign off_plus  = {1'b0, body_reg} + {{mfh_pkg::LEN_W{1'b0}}, 1'b1};
    assign body_last = off_plus >= {1'b0, accum_reg};

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        flags_next = flags_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        body_next  = body_reg;

        result.role   = mfh_pkg::ROLE_TYPE;
        result.kind   = kind_reg;
        result.flags  = flags_reg;
        result.rlen   = '0;
        result.offset = '0;
        result.eop    = 1'b0;
        result.err    = mfh_pkg::ERR_NONE;

        case (phase_reg)
            mfh_pkg::PH_ERR_MISMATCH, mfh_pkg::PH_ERR_OVERFLOW: begin
                result.role = mfh_pkg::ROLE_DROP;
                result.rlen = accum_reg;
                result.err  = (phase_reg == mfh_pkg::PH_ERR_MISMATCH) ?
                              mfh_pkg::ERR_MISMATCH : mfh_pkg::ERR_OVERFLOW;
            end
            mfh_pkg::PH_LEN: begin
                result.role = mfh_pkg::ROLE_LEN;
                result.rlen = accum_sum;
                accum_next  = accum_sum;
                if (mismatch) begin
                    phase_next = mfh_pkg::PH_ERR_MISMATCH;
                    result.err = mfh_pkg::ERR_MISMATCH;
                end else if (overflow) begin
                    phase_next = mfh_pkg::PH_ERR_OVERFLOW;
                    result.err = mfh_pkg::ERR_OVERFLOW;
                end else if (more) begin
                    count_next = count_reg + 2'd1;
                end else begin
                    body_next = '0;
                    if (accum_sum == '0) begin
                        // empty body: the length byte closes the packet
                        phase_next = mfh_pkg::PH_TYPE;
                        result.eop = 1'b1;
                    end else begin
                        phase_next = mfh_pkg::PH_BODY;
                    end
                end
            end
            mfh_pkg::PH_BODY: begin
                result.role   = mfh_pkg::ROLE_BODY;
                result.rlen   = accum_reg;
                result.offset = body_reg;
                result.eop    = body_last;
                body_next     = off_plus[mfh_pkg::LEN_W-1:0];
                if (body_last) begin
                    phase_next = mfh_pkg::PH_TYPE;
                end
            end
            default: begin
                kind_next    = byte_data[7:4];
                flags_next   = byte_data[3:0];
                accum_next   = '0;
                count_next   = '0;
                body_next    = '0;
                phase_next   = mfh_pkg::PH_LEN;
                result.kind  = byte_data[7:4];
                result.flags = byte_data[3:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mfh_pkg::PH_TYPE;
            kind_reg    <= '0;
            flags_reg   <= '0;
            accum_reg   <= '0;
            count_reg   <= '0;
            body_reg    <= '0;
            max_len_reg <= mfh_pkg::MAX_LENGTH_RESET;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                kind_reg  <= kind_next;
                flags_reg <= flags_next;
                accum_reg <= accum_next;
                count_reg <= count_next;
                body_reg  <= body_next;
            end
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/mfh_out_stage.sv
// Result register: holds one tagged byte until the sink takes it.
`default_nettype none
module mfh_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  wire mfh_pkg::result_t  result,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mfh_pkg::result_t       out_data
);

    logic             valid_reg;
    logic             valid_next;
    mfh_pkg::result_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

>>> hw/rtl/mqtt_fixed_header_deframer.sv
// Top level of the MQTT fixed-header deframer.
//
//  channel  direction  tdata                                   tuser      tlast
//  s_       in         rx_byte[7:0]                            -          -
//  m_       out        kind, flags, length, offset, error      byte_role  end of packet
//
// One byte per cycle sustained while m_tready stays high; an s_ request reaches m_ through
// the input register, then the framing state update into the result register.
// The framing state advances once per byte, so its state update loop sets the rate.
// aresetn is synchronous, active low; it returns the parser to the type byte,
// clears errors and sets max_length to its largest value.
// When m_tready is low the result register holds and s_tready drops once the
// input register is also full.
`default_nettype none
module mqtt_fixed_header_deframer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [mfh_pkg::LEN_W-1:0]     cfg_wr_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [mfh_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [3:0] packet_kind, [7:4] packet_flags, [35:8] remaining_length,
    // [63:36] body_offset, [65:64] error_code, [71:66] zero
    output logic [mfh_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                         m_tuser,   // [1:0] byte_role
    output logic                               m_tlast    // end_of_packet
);

    logic                       byte_valid;
    logic [mfh_pkg::BYTE_W-1:0] byte_data;
    logic                       advance;
    mfh_pkg::result_t           result;
    mfh_pkg::result_t           out_data;

    // move a byte into the result register when it is empty or draining
    assign advance = byte_valid && (!m_tvalid || m_tready);

    mfh_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    mfh_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .byte_data   (byte_data),
        .result      (result)
    );

    mfh_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .result    (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'd0, out_data.err, out_data.offset, out_data.rlen,
                      out_data.flags, out_data.kind};
    assign m_tuser = out_data.role;
    assign m_tlast = out_data.eop;

endmodule
`default_nettype wire

>>> hw/rtl/mfh_checker.sv
// Port-level checks on the deframer's result stream, bound to the top level.
`default_nettype none
`include "mqtt_fixed_header_deframer_macros.svh"
module mfh_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mfh_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [1:0]                    m_tuser,
    input wire logic                          m_tlast
);

    logic [mfh_pkg::M_TDATA_W+2:0] m_word;
    logic [1:0]                    m_role;
    logic [1:0]                    m_err;
    logic                          m_stall;
    logic                          m_clean;
    logic                          m_framed;
    logic                          m_is_type;
    logic                          m_is_drop;
    logic                          m_len_off_zero;

    assign m_word         = {m_tlast, m_tuser, m_tdata};
    assign m_role         = m_tuser;
    assign m_err          = m_tdata[65:64];
    assign m_stall        = m_tvalid && !m_tready;
    assign m_clean        = (m_err == mfh_pkg::ERR_NONE);
    assign m_framed       = (m_role == mfh_pkg::ROLE_LEN) || (m_role == mfh_pkg::ROLE_BODY);
    assign m_is_type      = m_tvalid && (m_role == mfh_pkg::ROLE_TYPE);
    assign m_is_drop      = m_tvalid && (m_role == mfh_pkg::ROLE_DROP);
    assign m_len_off_zero = (m_tdata[63:8] == '0);

    // a stalled request holds
    `MFH_ASSERT_NEXT(a_hold, aclk, aresetn, m_stall, m_tvalid && $stable(m_word))

    // a packet ends only on a clean length or body byte
    `MFH_ASSERT_NOW(a_eop_role, aclk, aresetn, m_tvalid && m_tlast, m_clean && m_framed)

    // dropped bytes only follow an error
    `MFH_ASSERT_NOW(a_drop_err, aclk, aresetn, m_is_drop, !m_clean)

    // a type byte carries no length and no offset
    `MFH_ASSERT_NOW(a_type_zero, aclk, aresetn, m_is_type, m_len_off_zero && !m_tlast)

endmodule

bind mqtt_fixed_header_deframer mfh_checker u_mfh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

>>> tb/tb_mqtt_fixed_header_deframer.sv
// Self-checking stream testbench for the MQTT fixed-header deframer.
module tb_mqtt_fixed_header_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    import mfh_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int NOISE_BYTES    = 40;
    localparam int PRINT_CAP      = 40;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    mqtt_fixed_header_deframer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // byte stream waiting to be offered, and tagged bytes still owed by the block
    logic [7:0] rx_bytes_q[$];
    result_t    tagged_q[$];

    // framing state of the predictor
    phase_t           fr_phase = PH_TYPE;
    logic [NIB_W-1:0] fr_kind = '0;
    logic [NIB_W-1:0] fr_flags = '0;
    logic [LEN_W-1:0] fr_len = '0;
    logic [CNT_W-1:0] fr_len_cnt = '0;
    logic [LEN_W-1:0] fr_body_cnt = '0;
    logic [LEN_W-1:0] fr_max_len = MAX_LENGTH_RESET;

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    logic s_took = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int hold_cnt = 0;
    int quiet_cycles = 0;

    int n_queued = 0;
    int n_bytes_in = 0;
    int n_results = 0;
    int n_packets = 0;
    int n_fail = 0;

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_fail < PRINT_CAP)
            $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
                     n_results, field, got, want);
        n_fail++;
    endtask

    // Advance the framing state by one received byte and queue its tag.
    task automatic tag_rx_byte(input logic [7:0] b);
        result_t    r;
        logic [6:0] val;
        logic       more;
        logic       bad;
        r = '0;
        r.role = ROLE_TYPE;
        r.err = ERR_NONE;
        val = b[6:0];
        more = b[7];
        bad = 1'b0;
        case (fr_phase)
            PH_ERR_MISMATCH, PH_ERR_OVERFLOW: begin
                r.role = ROLE_DROP;
                r.rlen = fr_len;
                r.err = (fr_phase == PH_ERR_MISMATCH) ? ERR_MISMATCH : ERR_OVERFLOW;
            end
            PH_LEN: begin
                fr_len = fr_len + (LEN_W'(val) << (7 * fr_len_cnt));
                r.role = ROLE_LEN;
                r.rlen = fr_len;
                if (fr_len_cnt == 0) begin
                    case (fr_kind)
                        KIND_CONNACK, KIND_PUBACK, KIND_PUBREL, KIND_PUBCOMP:
                            bad = more || (val != ACK_LENGTH);
                        KIND_PINGRESP:
                            bad = more || (val != PING_LENGTH);
                        default:
                            bad = 1'b0;
                    endcase
                end
                if (bad) begin
                    fr_phase = PH_ERR_MISMATCH;
                    r.err = ERR_MISMATCH;
                end else if (more) begin
                    if (fr_len > fr_max_len || fr_len_cnt == LAST_LEN_BYTE) begin
                        fr_phase = PH_ERR_OVERFLOW;
                        r.err = ERR_OVERFLOW;
                    end else begin
                        fr_len_cnt = fr_len_cnt + 1'b1;
                    end
                end else begin
                    fr_body_cnt = '0;
                    if (fr_len == 0) begin
                        // empty packet ends on its length byte
                        fr_phase = PH_TYPE;
                        r.eop = 1'b1;
                    end else begin
                        fr_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                r.role = ROLE_BODY;
                r.rlen = fr_len;
                r.offset = fr_body_cnt;
                r.eop = ({1'b0, fr_body_cnt} + 29'd1 >= {1'b0, fr_len});
                fr_body_cnt = fr_body_cnt + 1'b1;
                if (r.eop)
                    fr_phase = PH_TYPE;
            end
            default: begin
                fr_kind = b[7:4];
                fr_flags = b[3:0];
                fr_len = '0;
                fr_len_cnt = '0;
                fr_body_cnt = '0;
                fr_phase = PH_LEN;
            end
        endcase
        r.kind = fr_kind;
        r.flags = fr_flags;
        tagged_q.push_back(r);
    endtask

    function automatic bit is_fixed_kind(input logic [3:0] k);
        return k inside {KIND_CONNACK, KIND_PUBACK, KIND_PUBREL, KIND_PUBCOMP, KIND_PINGRESP};
    endfunction

    // A length of nb bytes passes only if every continued prefix stays within the limit.
    function automatic bit length_fits(input int unsigned len, input int unsigned nb);
        int unsigned k;
        for (k = 0; k + 1 < nb; k++)
            if ((len & ((32'd1 << (7 * (k + 1))) - 1)) > fr_max_len)
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic offer(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        n_queued++;
    endtask

    task automatic queue_random_packet();
        logic [3:0]  kind;
        int unsigned len;
        int unsigned nb;
        int unsigned pick;
        int unsigned k;
        logic [7:0]  b;
        kind = 4'($urandom_range(15));
        offer({kind, 4'($urandom_range(15))});
        if (is_fixed_kind(kind)) begin
            len = (kind == KIND_PINGRESP) ? PING_LENGTH : ACK_LENGTH;
            offer(8'(len));
        end else begin
            pick = $urandom_range(99);
            if (pick < 85)
                len = $urandom_range(8);
            else if (pick < 98)
                len = $urandom_range(140, 9);
            else
                len = $urandom_range(260, 141);
            nb = (len < 128) ? 1 : 2;
            // pad with zero groups now and then
            if ($urandom_range(3) == 0)
                nb = $urandom_range(4, nb);
            if (!length_fits(len, nb)) begin
                len = len & 32'h7F;
                nb = 1;
            end
            for (k = 0; k < nb; k++) begin
                b = 8'((len >> (7 * k)) & 32'h7F);
                if (k + 1 < nb)
                    b[7] = 1'b1;
                offer(b);
            end
        end
        repeat (len) offer(8'($urandom_range(255)));
    endtask

    task automatic queue_stream(input int target);
        while (n_queued < target)
            queue_random_packet();
    endtask

    task automatic wait_all_tagged();
        while (rx_bytes_q.size() != 0 || s_tvalid || tagged_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] v);
        wait_all_tagged();
        repeat (4) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        fr_max_len = v;
    endtask

    // sender: hold the offered byte until it is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_took) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= rx_bytes_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold on request
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == RX_HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_took <= 1'b0;
            fr_phase = PH_TYPE;
            fr_kind = '0;
            fr_flags = '0;
            fr_len = '0;
            fr_len_cnt = '0;
            fr_body_cnt = '0;
        end else begin
            s_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                tag_rx_byte(s_tdata);
                n_bytes_in++;
            end
        end
    end

    always @(posedge aclk) begin : check_tags
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tagged_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], 32'd0);
            end else begin
                want = tagged_q.pop_front();
                if (m_tuser !== want.role)
                    report_mismatch("byte_role", m_tuser, want.role);
                if (m_tdata[3:0] !== want.kind)
                    report_mismatch("packet_kind", m_tdata[3:0], want.kind);
                if (m_tdata[7:4] !== want.flags)
                    report_mismatch("packet_flags", m_tdata[7:4], want.flags);
                if (m_tdata[35:8] !== want.rlen)
                    report_mismatch("remaining_length", m_tdata[35:8], want.rlen);
                if (m_tdata[63:36] !== want.offset)
                    report_mismatch("body_offset", m_tdata[63:36], want.offset);
                if (m_tlast !== want.eop)
                    report_mismatch("end_of_packet", m_tlast, want.eop);
                if (m_tdata[65:64] !== want.err)
                    report_mismatch("error_code", m_tdata[65:64], want.err);
                if (m_tdata[71:66] !== '0)
                    report_mismatch("tdata padding", m_tdata[71:66], 32'd0);
                if (want.eop)
                    n_packets++;
            end
            n_results++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("timeout: no request moved for %0d cycles, %0d tags owed",
                         QUIET_LIMIT, tagged_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin : stimulus
        string      closing;
        logic [3:0] kind;
        logic [7:0] b;
        logic [LEN_W-1:0] lim;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extreme bytes, fixed-length types, empty packets, padded length field
        offer(8'h00); offer(8'h01); offer(8'hFF);
        offer(8'hFF); offer(8'h81); offer(8'h00); offer(8'h00);
        offer({KIND_PINGRESP, 4'h0}); offer(8'(PING_LENGTH));
        offer({KIND_CONNACK, 4'h0}); offer(8'(ACK_LENGTH));
        offer(8'($urandom_range(255))); offer(8'($urandom_range(255)));
        offer(8'hC0); offer(8'h00);
        offer(8'h3A); offer(8'h81); offer(8'h80); offer(8'h80); offer(8'h00); offer(8'h55);
        queue_stream(170);

        write_max_length('0);
        src_idle_pct = 87;
        queue_stream(n_queued + 230);

        write_max_length(LEN_W'(127));
        src_idle_pct = 0;
        snk_stall_pct = 87;
        queue_stream(n_queued + 230);

        write_max_length(LEN_W'($urandom_range(32'h0FFF_FFFF)));
        src_idle_pct = 8;
        snk_stall_pct = 8;
        queue_stream(n_queued + 230);

        // receiver holds off while the sender keeps offering
        write_max_length(MAX_LENGTH_RESET);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        queue_stream(n_queued + 120);
        @(negedge aclk);
        hold_req <= 1'b1;
        wait (hold_done);
        @(negedge aclk);
        hold_req <= 1'b0;
        queue_stream(n_queued + 110);
        wait_all_tagged();

        // errors are sticky, so the run closes with one framing error and noise
        case ($urandom_range(2))
            0: begin
                closing = "length mismatch";
                do kind = 4'($urandom_range(15)); while (!is_fixed_kind(kind));
                offer({kind, 4'($urandom_range(15))});
                if (kind == KIND_PINGRESP)
                    b = 8'($urandom_range(255, 1));
                else
                    do b = 8'($urandom_range(255)); while (b == 8'(ACK_LENGTH));
                offer(b);
            end
            1: begin
                closing = "length over the limit";
                lim = LEN_W'($urandom_range(126));
                write_max_length(lim);
                do kind = 4'($urandom_range(15)); while (is_fixed_kind(kind));
                offer({kind, 4'($urandom_range(15))});
                offer(8'h80 | 8'($urandom_range(127, 32'(lim) + 1)));
            end
            default: begin
                closing = "continued fourth length byte";
                do kind = 4'($urandom_range(15)); while (is_fixed_kind(kind));
                offer({kind, 4'($urandom_range(15))});
                repeat (4) offer(8'h80 | 8'($urandom_range(127)));
            end
        endcase
        repeat (NOISE_BYTES) offer(8'($urandom_range(255)));

        wait_all_tagged();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("covered %0d stream bytes, %0d tagged results, %0d whole packets",
                 n_bytes_in, n_results, n_packets);
        $display("five length limits and four idle mixes; closed by a %s", closing);
        if (n_fail == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mfh_pkg.sv
hw/rtl/mfh_in_stage.sv
hw/rtl/mfh_parser.sv
hw/rtl/mfh_out_stage.sv
hw/rtl/mqtt_fixed_header_deframer.sv
hw/rtl/mfh_checker.sv
tb/tb_mqtt_fixed_header_deframer.sv
